### design/sdds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the averaged-amplitude sine DDS.
// No dependencies; used by every module in design/ except sdds_ram.
package sdds_pkg;

    localparam int ADC_W      = 12;   // converter sample width
    localparam int DAC_W      = 12;   // DAC code width
    localparam int CFG_W      = 26;   // phase_step register width
    localparam int SINE_W     = 16;   // signed sine table entry width
    localparam int GAIN_W     = 12;   // amplitude width
    localparam int PHASE_FRAC = 16;   // fractional bits of the phase
    localparam int AMP_SHIFT  = 17;   // product scaling shift
    localparam int BUS_W      = 16;   // tdata width on both channels
    localparam int PROD_W     = SINE_W + GAIN_W + 1;

    localparam int          SINE_PEAK   = 32767;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

    localparam logic [CFG_W-1:0]  STEP_RESET = CFG_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(2048);
    localparam logic [DAC_W-1:0]  DAC_MID    = DAC_W'(2048);

    // Item kind carried on s_tuser.
    typedef enum logic {
        OP_ADC  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

endpackage

### design/sdds_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one registered read port.
// Write-first: a read of the address written in the same cycle returns the new data.
module sdds_ram #(
    parameter int WIDTH  = 12,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data <= wr_data;
        end else begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/sdds_avg.sv
`timescale 1ns / 1ps
// Boxcar averager: sample ring, running sum, gain = sum / AVG_DEPTH on each wrap.
// Uses sdds_pkg and sdds_ram.
module sdds_avg #(
    parameter int AVG_DEPTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr,          // converter item accepted
    input  logic [sdds_pkg::ADC_W-1:0] sample,
    output logic [sdds_pkg::GAIN_W-1:0] gain        // gain as seen by a tick now
);

    localparam int AW    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W = sdds_pkg::ADC_W + $clog2(AVG_DEPTH);
    // floor(n / D) == (n * RECIP) >> RSH for every n below 2**SUM_W
    localparam int RSH   = SUM_W + $clog2(AVG_DEPTH);
    localparam int RW    = RSH + 1;
    localparam int MUL_W = SUM_W + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RSH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    logic [AW-1:0]                  pos_reg, pos_next;
    logic                           last;
    logic                           wrapped_reg;    // every entry written once
    logic [SUM_W-1:0]               total_reg, total_next;
    logic                           load_reg;
    logic [sdds_pkg::GAIN_W-1:0]    gain_reg;
    logic [sdds_pkg::ADC_W-1:0]     rd_data, old_val;
    logic [MUL_W-1:0]               quot_prod;

    // RAM read runs one entry ahead so the entry being replaced is ready.
    sdds_ram #(
        .WIDTH (sdds_pkg::ADC_W),
        .DEPTH (AVG_DEPTH),
        .ADDR_W(AW)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (wr),
        .wr_addr(pos_reg),
        .wr_data(sample),
        .rd_addr(pos_next),
        .rd_data(rd_data)
    );

    always_comb begin
        last     = (pos_reg == AW'(AVG_DEPTH - 1));
        pos_next = pos_reg;
        if (wr) begin
            pos_next = last ? '0 : pos_reg + 1'b1;
        end
        old_val    = wrapped_reg ? rd_data : '0;
        total_next = total_reg - SUM_W'(old_val) + SUM_W'(sample);
        quot_prod  = MUL_W'(total_reg) * MUL_W'(RECIP);
        gain       = load_reg ? quot_prod[RSH +: sdds_pkg::GAIN_W] : gain_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            total_reg   <= '0;
            load_reg    <= 1'b0;
            gain_reg    <= sdds_pkg::GAIN_RESET;
        end else begin
            pos_reg  <= pos_next;
            load_reg <= wr && last;
            gain_reg <= gain;
            if (wr) begin
                total_reg <= total_next;
                if (last) begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### design/sdds_phase.sv
`timescale 1ns / 1ps
// Phase step register with modulo reduction, and the 10.16 phase accumulator (TABLE_SIZE = 1000).
// Uses sdds_pkg.
module sdds_phase #(
    parameter int TABLE_SIZE = 1000,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [sdds_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       tick,       // tick item accepted
    output logic                       busy,       // step reduction running
    output logic [IDX_W-1:0]           idx         // table index of the last tick
);

    localparam int PHASE_W   = $clog2(TABLE_SIZE + 1) + sdds_pkg::PHASE_FRAC;
    localparam int RED_STEPS = (PHASE_W > sdds_pkg::CFG_W) ? 1
                                                           : sdds_pkg::CFG_W - PHASE_W + 1;
    localparam int RED_W     = (PHASE_W > sdds_pkg::CFG_W) ? PHASE_W : sdds_pkg::CFG_W;
    localparam int CNT_W     = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam logic [PHASE_W-1:0] SPAN =
        PHASE_W'(64'(TABLE_SIZE) << sdds_pkg::PHASE_FRAC);
    localparam logic [RED_W-1:0] DIV_TOP = RED_W'(SPAN) << (RED_STEPS - 1);

    logic [RED_W-1:0]   step_reg;   // reduced to below SPAN once busy clears
    logic [RED_W-1:0]   div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W:0]   phase_sum;

    assign busy = busy_reg;
    assign idx  = phase_reg[sdds_pkg::PHASE_FRAC +: IDX_W];

    // Both terms are below SPAN, so one conditional subtract wraps the sum.
    always_comb begin
        phase_sum  = {1'b0, phase_reg} + {1'b0, step_reg[PHASE_W-1:0]};
        phase_next = phase_sum[PHASE_W-1:0];
        if (phase_sum >= {1'b0, SPAN}) begin
            phase_next = PHASE_W'(phase_sum - {1'b0, SPAN});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= RED_W'(sdds_pkg::STEP_RESET);
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= RED_W'(cfg_wr_data);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // restoring remainder, one quotient bit per cycle
                if (step_reg >= div_reg) begin
                    step_reg <= step_reg - div_reg;
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
            if (tick) begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cfg_wr_en) begin
            div_reg <= DIV_TOP;
            cnt_reg <= CNT_W'(RED_STEPS - 1);
        end else if (busy_reg) begin
            div_reg <= div_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### design/sdds_sine_rom.sv
`timescale 1ns / 1ps
// Signed sine table, truncated 32767*sin(2*pi*i/TABLE_SIZE), built at elaboration.
// Registered read. Uses sdds_pkg.
module sdds_sine_rom #(
    parameter int TABLE_SIZE = 1000,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                               aclk,
    input  logic                               rd_en,
    input  logic [IDX_W-1:0]                   rd_idx,
    output logic signed [sdds_pkg::SINE_W-1:0] rd_data
);

    localparam logic [63:0] Q_STEP = sdds_pkg::HALF_PI_Q60 / TABLE_SIZE;
    localparam logic [63:0] Q_REM  = sdds_pkg::HALF_PI_Q60 % TABLE_SIZE;

    // Taylor series of sin(x), x and result in Q60.
    function automatic logic [63:0] sin_q60(input logic [63:0] x);
        logic [127:0] p;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  acc;
        int           k;
        p    = {64'd0, x} * {64'd0, x};
        x2   = p[123:60];
        term = x;
        acc  = x;
        for (k = 1; k <= 14; k++) begin
            p    = {64'd0, term} * {64'd0, x2};
            term = p[123:60] / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    logic [sdds_pkg::SINE_W-1:0] rom_tab [TABLE_SIZE];

    for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_entry
        localparam int unsigned M4   = 4 * i;
        localparam int unsigned QUAD = M4 / TABLE_SIZE;
        localparam int unsigned REM  = M4 % TABLE_SIZE;
        // fold onto the first quadrant
        localparam int unsigned R    = (QUAD % 2 == 1) ? TABLE_SIZE - REM : REM;
        localparam logic [63:0] X    = Q_STEP * 64'(R) + (Q_REM * 64'(R)) / TABLE_SIZE;
        localparam logic [127:0] PK  = {64'd0, sin_q60(X)} * 128'(sdds_pkg::SINE_PEAK);
        localparam logic [15:0] MAG  = (REM == 0)
            ? ((QUAD % 2 == 1) ? 16'(sdds_pkg::SINE_PEAK) : 16'd0)
            : PK[75:60];
        localparam logic [15:0] VAL  = (QUAD >= 2) ? (16'd0 - MAG) : MAG;
        assign rom_tab[i] = VAL;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= signed'(rom_tab[rd_idx]);
        end
    end

endmodule

### design/sine_dds_with_averaged_amplitude.sv
`timescale 1ns / 1ps
// Top level of the averaged-amplitude sine DDS: handshakes and tick pipeline.
// Uses sdds_pkg, sdds_avg, sdds_phase, sdds_sine_rom.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser = op, s_tdata[11:0] = adc_value
//  m_       out  m_tvalid/m_tready  m_tdata[11:0] = dac_code
//  cfg_     in   cfg_wr_en          cfg_wr_data = phase_step
//
// One item per cycle while s_tready is high. A tick's dac_code reaches m_ through the
// phase register (set at acceptance), then the table read, multiply and output registers;
// a converter item gives none.
// A phase_step write holds s_tready low while the step is reduced modulo the table
// span, one quotient bit per cycle. Reset is synchronous, no clearing pass.
// Every stage has its own ready, so bubbles close up while m_tready is low.
module sine_dds_with_averaged_amplitude #(
    parameter int TABLE_SIZE = 1000,
    parameter int AVG_DEPTH  = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input items
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sdds_pkg::BUS_W-1:0] s_tdata,    // [11:0] adc_value
    input  logic                       s_tuser,    // [0] op
    // result items
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sdds_pkg::BUS_W-1:0] m_tdata,    // [11:0] dac_code
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [sdds_pkg::CFG_W-1:0] cfg_wr_data // phase_step
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic accept, is_tick;
    logic busy;
    logic [IDX_W-1:0]                  idx;
    logic [sdds_pkg::GAIN_W-1:0]       gain_cur;
    logic signed [sdds_pkg::SINE_W-1:0] sine;

    // stage 1: phase (held in sdds_phase), gain snapshot
    logic                              s1_valid_reg;
    logic [sdds_pkg::GAIN_W-1:0]       s1_gain_reg;
    // stage 2: table value (ROM output register), gain
    logic                              s2_valid_reg;
    logic [sdds_pkg::GAIN_W-1:0]       s2_gain_reg;
    // stage 3: product
    logic                              s3_valid_reg;
    logic signed [sdds_pkg::PROD_W-1:0] s3_prod_reg;
    // output register
    logic                              m_valid_reg;
    logic [sdds_pkg::DAC_W-1:0]        m_code_reg;

    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic signed [sdds_pkg::PROD_W-1:0] shifted;

    assign out_ready = !m_valid_reg || m_tready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign s_tready = !busy && s1_ready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == sdds_pkg::OP_TICK);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = sdds_pkg::BUS_W'(m_code_reg);

    sdds_avg #(
        .AVG_DEPTH(AVG_DEPTH)
    ) u_avg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr     (accept && !is_tick),
        .sample (s_tdata[sdds_pkg::ADC_W-1:0]),
        .gain   (gain_cur)
    );

    // phase_reg changes only when a tick enters stage 1, so it is stage 1's payload
    sdds_phase #(
        .TABLE_SIZE(TABLE_SIZE),
        .IDX_W     (IDX_W)
    ) u_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .tick       (accept && is_tick),
        .busy       (busy),
        .idx        (idx)
    );

    sdds_sine_rom #(
        .TABLE_SIZE(TABLE_SIZE),
        .IDX_W     (IDX_W)
    ) u_rom (
        .aclk   (aclk),
        .rd_en  (s1_valid_reg && s2_ready),
        .rd_idx (idx),
        .rd_data(sine)
    );

    // floor shift, then offset to mid-scale (wraps in 12 bits)
    assign shifted = s3_prod_reg >>> sdds_pkg::AMP_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= accept && is_tick;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_tick) begin
            s1_gain_reg <= gain_cur;
        end
        if (s2_ready) begin
            s2_gain_reg <= s1_gain_reg;
        end
        if (s3_ready) begin
            s3_prod_reg <= sdds_pkg::PROD_W'(sine)
                         * sdds_pkg::PROD_W'(signed'({1'b0, s2_gain_reg}));
        end
        if (out_ready) begin
            m_code_reg <= shifted[sdds_pkg::DAC_W-1:0] + sdds_pkg::DAC_MID;
        end
    end

    // a step write always blocks the next cycle's input
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted while phase step reduction pending");

    // converter items never enter the result pipeline
    a_adc_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_tick) |=> !s1_valid_reg)
        else $error("converter item produced a pipeline entry");

    // every accepted tick is in stage 1 on the next cycle
    a_tick_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_tick) |=> s1_valid_reg)
        else $error("accepted tick lost before stage 1");

    // a new result only shows up from a filled stage 3
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s3_valid_reg))
        else $error("result appeared without a stage 3 item");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sine_dds_with_averaged_amplitude: converter and tick items
// go in, DAC codes are predicted in-bench and compared item by item.
// Depends on sdds_pkg and the design sources only.
module tb_top;
    import sdds_pkg::*;

    localparam int          TAB_LEN    = 1000;
    localparam int          RING_LEN   = 32;
    localparam longint      PHASE_SPAN = longint'(TAB_LEN) << 16;
    localparam logic [63:0] Q60_QPI    = 64'h1921FB54442D1847;  // pi/2 in Q60

    // converter sample level used for one ring window of the random part
    typedef enum int {
        LVL_ANY,
        LVL_TOP,
        LVL_ZERO,
        LVL_NEAR_TOP,
        LVL_NEAR_ZERO
    } level_e;

    typedef struct {
        op_t              op;
        logic [ADC_W-1:0] adc;
    } dds_item_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // block ports, all driven to known values from time zero
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [BUS_W-1:0] s_tdata     = '0;
    logic             s_tuser     = 1'b0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [BUS_W-1:0] m_tdata;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    sine_dds_with_averaged_amplitude #(
        .TABLE_SIZE(TAB_LEN),
        .AVG_DEPTH (RING_LEN)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),      // [11:0] adc_value
        .s_tuser    (s_tuser),      // [0] op
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),      // [11:0] dac_code
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)   // phase_step
    );

    // ------------------------------------------------------------------
    // Predictor state: phase, step, averaging ring and the sine table.
    // ------------------------------------------------------------------
    logic signed [SINE_W-1:0] sine_lut [TAB_LEN];
    longint unsigned          phase_now = 0;
    logic [CFG_W-1:0]         step_now  = STEP_RESET;
    logic [ADC_W-1:0]         ring_mem [RING_LEN] = '{default: '0};
    int unsigned              ring_wr   = 0;
    int unsigned              ring_sum  = 0;
    logic [GAIN_W-1:0]        gain_now  = GAIN_RESET;

    logic [DAC_W-1:0] dac_due_q [$];   // expected DAC codes, oldest first
    dds_item_t        stim_q [$];      // items waiting for the driver

    int  queued_cnt = 0;
    int  taken_cnt  = 0;
    int  adc_sent   = 0;   // keeps random level windows aligned with the ring
    int  err_count  = 0;
    bit  s_fire     = 1'b0;
    bit  quiet_s    = 1'b0;
    bit  quiet_m    = 1'b0;
    int  send_wait  = 0;
    int  rx_hold    = 0;
    dds_item_t cur_item;

    // low 64 bits of (a*b) >> sh over the full 128-bit product
    function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> sh);
    endfunction

    // idle cycles before the next item; flips now and then into a no-idle stretch
    function automatic int gap_for(inout bit quiet);
        if ($urandom_range(0, 63) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    task automatic report_err(string msg);
        err_count++;
        if (err_count <= 50)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Sine table: truncated 32767*sin, one quarter by Taylor series in Q60,
    // the other quarters by symmetry; quarter points are exact.
    initial begin : build_sine
        logic [63:0] q, rm, x, x2, term, acc;
        int unsigned m, quad, rem, r;
        int          mag;
        q  = Q60_QPI / 64'(TAB_LEN);
        rm = Q60_QPI % 64'(TAB_LEN);
        for (int i = 0; i < TAB_LEN; i++) begin
            m    = 4 * i;
            quad = m / TAB_LEN;
            rem  = m % TAB_LEN;
            if (rem == 0) begin
                mag = quad[0] ? SINE_PEAK : 0;
            end else begin
                r    = quad[0] ? TAB_LEN - rem : rem;
                x    = q * 64'(r) + (rm * 64'(r)) / 64'(TAB_LEN);
                x2   = mulsh(x, x, 60);
                term = x;
                acc  = x;
                for (int k = 1; k <= 14; k++) begin
                    term = mulsh(term, x2, 60) / 64'((2 * k) * (2 * k + 1));
                    if (k % 2)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
                mag = int'(mulsh(acc, 64'(SINE_PEAK), 60));
            end
            sine_lut[i] = SINE_W'(quad >= 2 ? -mag : mag);
        end
    end

    // ------------------------------------------------------------------
    // Input side. Acceptance is sampled at the rising edge and fed to the
    // predictor; the driver moves on at the falling edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : accept_side
        longint prod;
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            taken_cnt++;
            if (cur_item.op == OP_TICK) begin
                // advance the phase, look up, scale with floor shift, re-center
                phase_now = (phase_now + 64'(step_now)) % PHASE_SPAN;
                prod = longint'(sine_lut[phase_now >> PHASE_FRAC]) * longint'(gain_now);
                dac_due_q.push_back(DAC_W'((prod >>> AMP_SHIFT) + longint'(DAC_MID)));
            end else begin
                // boxcar: swap the oldest sample out of the running sum
                ring_sum = ring_sum + cur_item.adc - ring_mem[ring_wr];
                ring_mem[ring_wr] = cur_item.adc;
                ring_wr = (ring_wr + 1) % RING_LEN;
                if (ring_wr == 0)
                    gain_now = GAIN_W'(ring_sum / RING_LEN);
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_fire) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    cur_item = stim_q.pop_front();
                    s_tuser  <= cur_item.op;
                    s_tdata  <= BUS_W'(cur_item.adc);
                    s_tvalid <= 1'b1;
                    send_wait = gap_for(quiet_s);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order comparison.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        logic [DAC_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            rx_hold = gap_for(quiet_m);
            if (dac_due_q.size() == 0) begin
                report_err($sformatf("unexpected result tdata=%h", m_tdata));
            end else begin
                want = dac_due_q.pop_front();
                // padding above dac_code must read zero
                if (m_tdata !== BUS_W'(want))
                    report_err($sformatf("dac_code got %h want %h", m_tdata, want));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_item(op_t op, logic [ADC_W-1:0] v);
        dds_item_t it;
        it.op  = op;
        it.adc = v;
        stim_q.push_back(it);
        queued_cnt++;
        if (op == OP_ADC)
            adc_sent++;
    endtask

    // Wait for every item taken and every result back, then let the pipe empty;
    // converter items leave nothing to wait on, so allow the full latency.
    task automatic drain_idle();
        do
            @(negedge aclk);
        while (taken_cnt != queued_cnt || dac_due_q.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_step(logic [CFG_W-1:0] v);
        drain_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        step_now     = v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Ticks interleaved with converter samples; each ring window gets one
    // level so that full-scale and zero amplitudes are reached too.
    task automatic random_phase(int n);
        level_e           lvl;
        int unsigned      pick;
        logic [ADC_W-1:0] v;
        lvl = LVL_ANY;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 4) begin
                push_item(OP_TICK, ADC_W'($urandom));   // adc field ignored on ticks
            end else begin
                if (adc_sent % RING_LEN == 0) begin
                    pick = $urandom_range(0, 7);
                    lvl  = (pick > LVL_NEAR_ZERO) ? LVL_ANY : level_e'(pick);
                end
                case (lvl)
                    LVL_TOP:       v = '1;
                    LVL_ZERO:      v = '0;
                    LVL_NEAR_TOP:  v = ADC_W'(4095 - $urandom_range(0, 15));
                    LVL_NEAR_ZERO: v = ADC_W'($urandom_range(0, 15));
                    default:       v = ADC_W'($urandom_range(0, 4095));
                endcase
                push_item(OP_ADC, v);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset step and reset amplitude first
        push_item(OP_TICK, '0);
        push_item(OP_TICK, '1);
        push_item(OP_ADC, 12'hFFF);
        push_item(OP_ADC, 12'h000);
        push_item(OP_ADC, 12'hAAA);
        push_item(OP_ADC, 12'h555);
        push_item(OP_TICK, 12'h0);

        // quarter-period steps: ticks a quarter turn apart, one of them wrapping
        set_step(CFG_W'(250 << PHASE_FRAC));
        repeat (5) push_item(OP_TICK, 12'h0);

        // zero step holds the phase
        set_step('0);
        push_item(OP_TICK, 12'h0);
        push_item(OP_ADC, 12'hFFF);
        push_item(OP_TICK, 12'h0);

        // largest legal step, one fraction short of a full turn
        set_step(CFG_W'(65535999));
        repeat (2) push_item(OP_TICK, 12'h0);

        // out-of-range step has to be reduced modulo the table span
        set_step('1);
        repeat (3) push_item(OP_TICK, 12'h0);

        // pure fractional step
        set_step(CFG_W'(1));
        repeat (2) push_item(OP_TICK, 12'h0);

        // random part, one step setting per phase
        set_step(CFG_W'($urandom_range(1, 65535999)));
        random_phase(250);
        set_step(CFG_W'($urandom_range(1, 1 << 20)));
        random_phase(250);
        set_step('1);
        random_phase(250);
        set_step(CFG_W'(65535999));
        random_phase(250);
        set_step(CFG_W'($urandom));
        random_phase(250);
        set_step('0);
        random_phase(100);
        set_step(CFG_W'($urandom_range(65536, 8 * 65536)));
        random_phase(400);

        drain_idle();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sine_dds_with_averaged_amplitude.f
design/sdds_pkg.sv
design/sdds_ram.sv
design/sdds_avg.sv
design/sdds_phase.sv
design/sdds_sine_rom.sv
design/sine_dds_with_averaged_amplitude.sv
test/tb_top.sv
